// File: hdl/rsrt_pkg.sv
// shared types and constants of the rtcp sender rtt tracker
package rsrt_pkg;

    localparam int SR_SLOTS_DEFAULT = 4;

    // request kinds
    localparam logic [1:0] KIND_RTP = 2'd0;
    localparam logic [1:0] KIND_SR  = 2'd1;
    localparam logic [1:0] KIND_RR  = 2'd2;

    // dlsr is in 1/65536 s, rtt is in ms
    localparam int DLSR_SCALE = 1000;
    localparam int DLSR_SHIFT = 16;
    localparam int PROD_W     = 32 + 10;
    localparam int DELAY_W    = PROD_W - DLSR_SHIFT;

    // only the low word of the time difference decides the rtt
    localparam int TIME_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // one classified request between front and back
    typedef struct packed {
        logic                is_rtp;
        logic                is_sr;
        logic                is_rr;
        logic [15:0]         octets;
        logic [31:0]         rtp_stamp;
        logic [63:0]         ntp_ms;
        logic [31:0]         sr_key;
        logic [DELAY_W-1:0]  delay;
        logic [31:0]         report_ssrc;
        logic [TIME_W-1:0]   now_low;
    } rsrt_item_t;

endpackage

// File: hdl/rsrt_front.sv
// front end: decodes the request kind and scales dlsr to milliseconds
module rsrt_front
    import rsrt_pkg::*;
(
    input  logic [1:0]  kind,
    input  logic [15:0] octets,
    input  logic [31:0] rtp_stamp,
    input  logic [63:0] ntp_ms,
    input  logic [31:0] sr_key,
    input  logic [31:0] dlsr,
    input  logic [31:0] report_ssrc,
    input  logic [63:0] now_ms,
    output rsrt_item_t  item
);

    logic [PROD_W-1:0] dlsr_prod;

    // dlsr * 1000 / 65536, truncated
    assign dlsr_prod = {{(PROD_W-32){1'b0}}, dlsr} * PROD_W'(DLSR_SCALE);

    always_comb
    begin
        item.is_rtp      = (kind == KIND_RTP);
        item.is_sr       = (kind == KIND_SR);
        item.is_rr       = (kind == KIND_RR);
        item.octets      = octets;
        item.rtp_stamp   = rtp_stamp;
        item.ntp_ms      = ntp_ms;
        item.sr_key      = sr_key;
        item.delay       = dlsr_prod[PROD_W-1:DLSR_SHIFT];
        item.report_ssrc = report_ssrc;
        item.now_low     = now_ms[TIME_W-1:0];
    end

endmodule

// File: hdl/rsrt_queue.sv
// short fifo of classified requests between front and back
module rsrt_queue
    import rsrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rsrt_item_t push_item,
    output logic       full,
    input  logic       pop,
    output rsrt_item_t pop_item,
    output logic       empty
);

    rsrt_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/rsrt_back.sv
// back end: counters, sr send table and rtt measurement with result register
module rsrt_back
    import rsrt_pkg::*;
#(
    parameter int SR_SLOTS = SR_SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  rsrt_item_t  item,
    input  logic        item_avail,
    output logic        item_take,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        rtt_valid,
    output logic [30:0] rtt_ms,
    output logic [31:0] rtt_ssrc,
    output logic [31:0] sent_packets,
    output logic [31:0] sent_octets,
    output logic [31:0] last_rtp_stamp,
    output logic [63:0] last_ntp_ms
);

    localparam int SLOT_W = (SR_SLOTS > 1) ? $clog2(SR_SLOTS) : 1;

    logic [31:0]       slot_key_reg  [SR_SLOTS];
    logic [TIME_W-1:0] slot_time_reg [SR_SLOTS];
    logic [SR_SLOTS-1:0] slot_used_reg, slot_used_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;

    logic [31:0] packets_reg, packets_next;
    logic [31:0] octets_reg, octets_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [63:0] ntp_reg, ntp_next;

    logic        out_valid_reg, out_valid_next;
    logic        rtt_valid_reg, rtt_valid_next;
    logic [30:0] rtt_ms_reg, rtt_ms_next;
    logic [31:0] rtt_ssrc_reg, rtt_ssrc_next;

    logic [SR_SLOTS-1:0] hit;
    logic                hit_any;
    logic [SLOT_W-1:0]   hit_idx;
    logic [SLOT_W-1:0]   wr_idx;
    logic                slot_wr;
    logic [TIME_W-1:0]   diff;

    assign item_take = item_avail && (!out_valid_reg || out_ready);

    // parallel key compare, lowest matching slot wins
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < SR_SLOTS; i++)
        begin
            hit[i] = slot_used_reg[i] && (slot_key_reg[i] == item.sr_key);
        end
        for (int i = SR_SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign hit_any = |hit;
    assign diff    = item.now_low - slot_time_reg[hit_idx]
                     - {{(TIME_W-DELAY_W){1'b0}}, item.delay};

    always_comb
    begin
        packets_next   = packets_reg;
        octets_next    = octets_reg;
        stamp_next     = stamp_reg;
        ntp_next       = ntp_reg;
        slot_used_next = slot_used_reg;
        oldest_next    = oldest_reg;
        slot_wr        = 1'b0;
        wr_idx         = hit_idx;
        out_valid_next = out_valid_reg && !out_ready;
        rtt_valid_next = rtt_valid_reg;
        rtt_ms_next    = rtt_ms_reg;
        rtt_ssrc_next  = rtt_ssrc_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
            rtt_valid_next = 1'b0;
            rtt_ms_next    = '0;
            rtt_ssrc_next  = '0;
            if (item.is_rtp)
            begin
                packets_next = packets_reg + 32'd1;
                octets_next  = octets_reg + {16'd0, item.octets};
                stamp_next   = item.rtp_stamp;
                ntp_next     = item.ntp_ms;
            end
            if (item.is_sr)
            begin
                slot_wr = 1'b1;
                if (!hit_any)
                begin
                    wr_idx                 = oldest_reg;
                    slot_used_next[oldest_reg] = 1'b1;
                    if (oldest_reg == SLOT_W'(SR_SLOTS - 1))
                    begin
                        oldest_next = '0;
                    end
                    else
                    begin
                        oldest_next = oldest_reg + 1'b1;
                    end
                end
            end
            if (item.is_rr && (item.sr_key != '0) && hit_any && !diff[TIME_W-1])
            begin
                rtt_valid_next = 1'b1;
                rtt_ms_next    = diff[30:0];
                rtt_ssrc_next  = item.report_ssrc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packets_reg   <= '0;
            octets_reg    <= '0;
            stamp_reg     <= '0;
            ntp_reg       <= '0;
            slot_used_reg <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            packets_reg   <= packets_next;
            octets_reg    <= octets_next;
            stamp_reg     <= stamp_next;
            ntp_reg       <= ntp_next;
            slot_used_reg <= slot_used_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rtt_valid_reg <= rtt_valid_next;
        rtt_ms_reg    <= rtt_ms_next;
        rtt_ssrc_reg  <= rtt_ssrc_next;
        if (slot_wr)
        begin
            slot_key_reg[wr_idx]  <= item.sr_key;
            slot_time_reg[wr_idx] <= item.now_low;
        end
    end

    // state only moves when a result is loaded, so it is the result itself
    assign out_valid      = out_valid_reg;
    assign rtt_valid      = rtt_valid_reg;
    assign rtt_ms         = rtt_ms_reg;
    assign rtt_ssrc       = rtt_ssrc_reg;
    assign sent_packets   = packets_reg;
    assign sent_octets    = octets_reg;
    assign last_rtp_stamp = stamp_reg;
    assign last_ntp_ms    = ntp_reg;

endmodule

// File: hdl/rtcp_sender_rtt_tracker_core.sv
// top level of the rtcp sender rtt tracker
//
// usage
// - input channel (in_valid / in_ready) carries one request per event:
//   kind 0 rtp packet sent, kind 1 sender report sent, kind 2 receiver
//   report block; kind 3 changes nothing
// - output channel (out_valid / out_ready) returns exactly one result per
//   request, in order: rtt of a matched report block plus the sender counters
// - an accepted request is written into the queue, and the back loads its result
//   into the result register when the output is free
// - throughput: one request per cycle while in_ready is high; the front decodes and
//   scales dlsr with a 32x10 constant multiply, the back does the sr table compare
//   and the 32-bit rtt subtract for each request
// - a two-entry queue parts front and back, so a request is still taken while
//   a result waits; with out_ready low two more requests are buffered, then
//   in_ready drops
// - reset clears counters, latched stamps, table used bits, the fifo pointer
//   of the table and the queue; table keys and times need no reset
// - the sr table holds SR_SLOTS entries, replaced oldest first
module rtcp_sender_rtt_tracker_core
    import rsrt_pkg::*;
#(
    parameter int SR_SLOTS = SR_SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] octets,
    input  logic [31:0] rtp_stamp,
    input  logic [63:0] ntp_ms,
    input  logic [31:0] sr_key,
    input  logic [31:0] dlsr,
    input  logic [31:0] report_ssrc,
    input  logic [63:0] now_ms,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        rtt_valid,
    output logic [30:0] rtt_ms,
    output logic [31:0] rtt_ssrc,
    output logic [31:0] sent_packets,
    output logic [31:0] sent_octets,
    output logic [31:0] last_rtp_stamp,
    output logic [63:0] last_ntp_ms
);

    rsrt_item_t front_item;
    rsrt_item_t back_item;
    logic       queue_full;
    logic       queue_empty;
    logic       back_take;

    // decode kind and convert dlsr into ms
    rsrt_front u_front
    (
        .kind        (kind),
        .octets      (octets),
        .rtp_stamp   (rtp_stamp),
        .ntp_ms      (ntp_ms),
        .sr_key      (sr_key),
        .dlsr        (dlsr),
        .report_ssrc (report_ssrc),
        .now_ms      (now_ms),
        .item        (front_item)
    );

    assign in_ready = !queue_full;

    // decoupling queue
    rsrt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (back_take),
        .pop_item  (back_item),
        .empty     (queue_empty)
    );

    // state, sr table and result register
    rsrt_back #(
        .SR_SLOTS (SR_SLOTS)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (back_item),
        .item_avail     (!queue_empty),
        .item_take      (back_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rtt_valid      (rtt_valid),
        .rtt_ms         (rtt_ms),
        .rtt_ssrc       (rtt_ssrc),
        .sent_packets   (sent_packets),
        .sent_octets    (sent_octets),
        .last_rtp_stamp (last_rtp_stamp),
        .last_ntp_ms    (last_ntp_ms)
    );

endmodule

// File: tb/rtt_tracker_checker.sv
// request/result checker with its own model of the rtt tracker
`timescale 1ns / 100ps

module rtt_tracker_checker
    import rsrt_pkg::*;
#(
    parameter int SR_SLOTS = SR_SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] octets,
    input  logic [31:0] rtp_stamp,
    input  logic [63:0] ntp_ms,
    input  logic [31:0] sr_key,
    input  logic [31:0] dlsr,
    input  logic [31:0] report_ssrc,
    input  logic [63:0] now_ms,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        rtt_valid,
    input  logic [30:0] rtt_ms,
    input  logic [31:0] rtt_ssrc,
    input  logic [31:0] sent_packets,
    input  logic [31:0] sent_octets,
    input  logic [31:0] last_rtp_stamp,
    input  logic [63:0] last_ntp_ms,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic        rtt_valid;
        logic [30:0] rtt_ms;
        logic [31:0] rtt_ssrc;
        logic [31:0] sent_packets;
        logic [31:0] sent_octets;
        logic [31:0] last_rtp_stamp;
        logic [63:0] last_ntp_ms;
    } tracker_report_t;

    tracker_report_t expected_reports[$];
    tracker_report_t due_report;
    tracker_report_t next_report;

    // model state
    logic [31:0] packets_seen;
    logic [31:0] octets_seen;
    logic [31:0] stamp_seen;
    logic [63:0] ntp_seen;
    logic [31:0] sr_table_key [SR_SLOTS];
    logic [63:0] sr_table_time [SR_SLOTS];
    logic        sr_table_used [SR_SLOTS];
    int unsigned next_victim;

    // used entry holding the key, -1 when none
    function automatic int sr_entry_of(input logic [31:0] key);
        for (int i = 0; i < SR_SLOTS; i++)
        begin
            if (sr_table_used[i] && sr_table_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    task automatic track_request(output tracker_report_t rep);
        logic [63:0] dlsr_delay;
        logic [63:0] elapsed;
        int          hit;
        rep = '0;
        case (kind)
            KIND_RTP:
            begin
                packets_seen = packets_seen + 32'd1;
                octets_seen  = octets_seen + {16'd0, octets};
                stamp_seen   = rtp_stamp;
                ntp_seen     = ntp_ms;
            end
            KIND_SR:
            begin
                hit = sr_entry_of(sr_key);
                if (hit >= 0)
                    sr_table_time[hit] = now_ms;
                else
                begin
                    sr_table_key[next_victim]  = sr_key;
                    sr_table_time[next_victim] = now_ms;
                    sr_table_used[next_victim] = 1'b1;
                    next_victim = (next_victim + 1) % SR_SLOTS;
                end
            end
            KIND_RR:
            begin
                hit = (sr_key != 32'd0) ? sr_entry_of(sr_key) : -1;
                if (hit >= 0)
                begin
                    dlsr_delay = ({32'd0, dlsr} * 64'(DLSR_SCALE)) >> DLSR_SHIFT;
                    elapsed    = now_ms - sr_table_time[hit] - dlsr_delay;
                    // only the low word counts, its sign decides validity
                    if (!elapsed[31])
                    begin
                        rep.rtt_valid = 1'b1;
                        rep.rtt_ms    = elapsed[30:0];
                        rep.rtt_ssrc  = report_ssrc;
                    end
                end
            end
            default: ;
        endcase
        rep.sent_packets   = packets_seen;
        rep.sent_octets    = octets_seen;
        rep.last_rtp_stamp = stamp_seen;
        rep.last_ntp_ms    = ntp_seen;
    endtask

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packets_seen = '0;
            octets_seen  = '0;
            stamp_seen   = '0;
            ntp_seen     = '0;
            for (int i = 0; i < SR_SLOTS; i++)
                sr_table_used[i] = 1'b0;
            next_victim = 0;
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request waiting, expected none, actual %0h",
                             $time, sent_packets);
                end
                else
                begin
                    due_report = expected_reports.pop_front();
                    compare_field("rtt_valid", due_report.rtt_valid, rtt_valid);
                    compare_field("rtt_ms", due_report.rtt_ms, rtt_ms);
                    compare_field("rtt_ssrc", due_report.rtt_ssrc, rtt_ssrc);
                    compare_field("sent_packets", due_report.sent_packets, sent_packets);
                    compare_field("sent_octets", due_report.sent_octets, sent_octets);
                    compare_field("last_rtp_stamp", due_report.last_rtp_stamp,
                                  last_rtp_stamp);
                    compare_field("last_ntp_ms", due_report.last_ntp_ms, last_ntp_ms);
                end
            end
            if (in_valid && in_ready)
            begin
                track_request(next_report);
                expected_reports.push_back(next_report);
            end
            pending <= expected_reports.size();
        end
    end

endmodule

// File: tb/tb_rtcp_sender_rtt_tracker_core.sv
// top of the rtt tracker testbench: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_rtcp_sender_rtt_tracker_core;
    import rsrt_pkg::*;

    // kind with no meaning, the block must leave its state alone
    localparam logic [1:0] KIND_NONE = 2'd3;
    // cycles with no handshake at all before the run is declared hung
    localparam int QUIET_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = '0;
    logic [15:0] octets = '0;
    logic [31:0] rtp_stamp = '0;
    logic [63:0] ntp_ms = '0;
    logic [31:0] sr_key = '0;
    logic [31:0] dlsr = '0;
    logic [31:0] report_ssrc = '0;
    logic [63:0] now_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        rtt_valid;
    logic [30:0] rtt_ms;
    logic [31:0] rtt_ssrc;
    logic [31:0] sent_packets;
    logic [31:0] sent_octets;
    logic [31:0] last_rtp_stamp;
    logic [63:0] last_ntp_ms;

    int          errors;
    int          pending;
    int          quiet_cycles = 0;

    // idling switches, flipped per stretch of the random part
    bit          tx_idle_en = 1'b0;
    bit          rx_stall_en = 1'b0;

    // wall clock of the stimulus and the keys that sender reports draw from
    logic [63:0] wall_ms = '0;
    logic [31:0] key_pool [8];

    rtcp_sender_rtt_tracker_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .octets         (octets),
        .rtp_stamp      (rtp_stamp),
        .ntp_ms         (ntp_ms),
        .sr_key         (sr_key),
        .dlsr           (dlsr),
        .report_ssrc    (report_ssrc),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rtt_valid      (rtt_valid),
        .rtt_ms         (rtt_ms),
        .rtt_ssrc       (rtt_ssrc),
        .sent_packets   (sent_packets),
        .sent_octets    (sent_octets),
        .last_rtp_stamp (last_rtp_stamp),
        .last_ntp_ms    (last_ntp_ms)
    );

    rtt_tracker_checker tracker_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .octets         (octets),
        .rtp_stamp      (rtp_stamp),
        .ntp_ms         (ntp_ms),
        .sr_key         (sr_key),
        .dlsr           (dlsr),
        .report_ssrc    (report_ssrc),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rtt_valid      (rtt_valid),
        .rtt_ms         (rtt_ms),
        .rtt_ssrc       (rtt_ssrc),
        .sent_packets   (sent_packets),
        .sent_octets    (sent_octets),
        .last_rtp_stamp (last_rtp_stamp),
        .last_ntp_ms    (last_ntp_ms),
        .errors         (errors),
        .pending        (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // hang detection: any handshake resets the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: ready high, with random stall bursts when enabled
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_stall_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand_wide();
        return {$urandom(), $urandom()};
    endfunction

    // present one request and hold it until taken, then maybe idle a burst
    task automatic offer_request(input logic [1:0] k, input logic [15:0] oct,
                                 input logic [31:0] stamp, input logic [63:0] ntp,
                                 input logic [31:0] key, input logic [31:0] delay_units,
                                 input logic [31:0] ssrc, input logic [63:0] now);
        kind        <= k;
        octets      <= oct;
        rtp_stamp   <= stamp;
        ntp_ms      <= ntp;
        sr_key      <= key;
        dlsr        <= delay_units;
        report_ssrc <= ssrc;
        now_ms      <= now;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // mostly well-formed traffic: packets, reports, matching report blocks
    task automatic offer_random_request();
        int unsigned  pick;
        int unsigned  dl_pick;
        logic [31:0]  delay_units;
        logic [15:0]  oct;
        logic [31:0]  key;
        wall_ms = wall_ms + 64'($urandom_range(0, 400));
        pick    = $urandom_range(0, 99);
        dl_pick = $urandom_range(0, 19);
        // delay mostly under a second, sometimes long, full range or zero
        if (dl_pick < 14)
            delay_units = $urandom_range(0, 65536);
        else if (dl_pick < 17)
            delay_units = $urandom_range(0, 65536 * 4);
        else if (dl_pick < 19)
            delay_units = $urandom();
        else
            delay_units = '0;
        case ($urandom_range(0, 9))
            0:       oct = 16'hFFFF;
            1:       oct = 16'h0000;
            default: oct = 16'($urandom());
        endcase
        key = key_pool[$urandom_range(0, 7)];
        if (pick < 35)
            offer_request(KIND_RTP, oct, $urandom(),
                          $urandom_range(0, 1) ? wall_ms : rand_wide(),
                          $urandom(), $urandom(), $urandom(), rand_wide());
        else if (pick < 60)
            offer_request(KIND_SR, oct, $urandom(), rand_wide(), key,
                          $urandom(), $urandom(), wall_ms);
        else if (pick < 88)
            offer_request(KIND_RR, oct, $urandom(), rand_wide(), key,
                          delay_units, $urandom(), wall_ms);
        else if (pick < 93)
            // report block naming a key that is unlikely to be held, or none
            offer_request(KIND_RR, oct, $urandom(), rand_wide(),
                          $urandom_range(0, 1) ? $urandom() : 32'd0,
                          delay_units, $urandom(), wall_ms);
        else if (pick < 96)
            offer_request(KIND_NONE, oct, $urandom(), rand_wide(), key,
                          $urandom(), $urandom(), rand_wide());
        else
            offer_request(2'($urandom()), oct, $urandom(), rand_wide(), $urandom(),
                          $urandom(), $urandom(), rand_wide());
    endtask

    task automatic refresh_key_pool();
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        // a zero key is legal for a report sent but means no lsr in a block
        if ($urandom_range(0, 1))
            key_pool[0] = 32'd0;
        if ($urandom_range(0, 1))
            key_pool[7] = 32'hFFFF_FFFF;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        // report block against an empty table, then one with no lsr
        offer_request(KIND_RR, '0, '0, '0, 32'd5, '0, $urandom(), 64'd100);
        offer_request(KIND_RR, '0, '0, '0, 32'd0, '0, $urandom(), 64'd200);
        // packet fields at both extremes
        offer_request(KIND_RTP, 16'hFFFF, 32'hFFFF_FFFF, '1, '0, '0, '0, '0);
        offer_request(KIND_RTP, 16'h0000, '0, '0, '1, '1, '1, '1);
        // zero key is stored, but a block with zero lsr still gives no rtt
        offer_request(KIND_SR, '0, '0, '0, 32'd0, '0, '0, 64'd1000);
        offer_request(KIND_RR, '0, '0, '0, 32'd0, '0, $urandom(), 64'd2000);
        // time wraps through 2^64 between report and block
        offer_request(KIND_SR, '0, '0, '0, 32'hFFFF_FFFF, '0, '0,
                      64'hFFFF_FFFF_FFFF_FF00);
        offer_request(KIND_RR, '0, '0, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 64'h100);
        // fill the table, refresh one key, then evict the two oldest
        offer_request(KIND_SR, '0, '0, '0, 32'd1, '0, '0, 64'd5000);
        offer_request(KIND_SR, '0, '0, '0, 32'd2, '0, '0, 64'd5000);
        offer_request(KIND_SR, '0, '0, '0, 32'd3, '0, '0, 64'd6000);
        offer_request(KIND_SR, '0, '0, '0, 32'd1, '0, '0, 64'd7000);
        offer_request(KIND_SR, '0, '0, '0, 32'd4, '0, '0, 64'd7000);
        // evicted key no longer matches
        offer_request(KIND_RR, '0, '0, '0, 32'hFFFF_FFFF, '0, $urandom(), 64'd8000);
        // rtt exactly zero, then one below zero
        offer_request(KIND_RR, '0, '0, '0, 32'd1, 32'd65536, $urandom(), 64'd8000);
        offer_request(KIND_RR, '0, '0, '0, 32'd2, 32'd65536, $urandom(), 64'd5999);
        // largest rtt, then sign bit of the low word set
        offer_request(KIND_RR, '0, '0, '0, 32'd3, '0, $urandom(),
                      64'd6000 + 64'h7FFF_FFFF);
        offer_request(KIND_RR, '0, '0, '0, 32'd3, '0, $urandom(),
                      64'd6000 + 64'h8000_0000);
        // longest dlsr
        offer_request(KIND_RR, '0, '0, '0, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      64'd7000 + 64'd65535999 + 64'd12345);
        // high word of the difference is ignored
        offer_request(KIND_RR, '0, '0, '0, 32'd2, '0, $urandom(),
                      64'd5000 + 64'h1_0000_0000 + 64'd10);
        // unknown kind with every field high
        offer_request(KIND_NONE, '1, '1, '1, 32'd1, '1, '1, '1);

        // random part in stretches with different idling
        wall_ms = rand_wide();
        for (int chunk = 0; chunk < 16; chunk++)
        begin
            tx_idle_en  = ($urandom_range(0, 2) != 0);
            rx_stall_en = ($urandom_range(0, 2) != 0);
            refresh_key_pool();
            for (int n = 0; n < 50; n++)
                offer_random_request();
        end

        // last part runs at full rate on both sides
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        refresh_key_pool();
        for (int n = 0; n < 150; n++)
            offer_random_request();

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: rtcp_sender_rtt_tracker_core.f
hdl/rsrt_pkg.sv
hdl/rsrt_front.sv
hdl/rsrt_queue.sv
hdl/rsrt_back.sv
hdl/rtcp_sender_rtt_tracker_core.sv
tb/rtt_tracker_checker.sv
tb/tb_rtcp_sender_rtt_tracker_core.sv
